>>> rtl/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Types, constants and arithmetic steps for the cylinder surface projection.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int GROUP_BITS   = 16;
  localparam int GIDX_BITS    = $clog2(GROUP_BITS);
  localparam int TG_BITS      = 5;
  localparam int CFG_IDX_BITS = 3;

  localparam int SQRT_STEPS = 32;
  localparam int DIV1_STEPS = 31;
  localparam int DIV2_STEPS = 15;
  localparam int PIPE_DEPTH = 3 + SQRT_STEPS + 2 + DIV1_STEPS + 7 + SQRT_STEPS + 1 + DIV2_STEPS;

  localparam logic [30:0]        RADIUS_RST   = 31'd65536;
  localparam logic signed [31:0] Z_LOW_RST    = -32'sd655360;
  localparam logic signed [31:0] Z_HIGH_RST   = 32'sd655360;
  localparam logic [30:0]        BOX_RST      = 31'd1310720;
  localparam logic [TG_BITS-1:0] TG_ALL       = TG_BITS'(GROUP_BITS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RADIUS   = 3'd0,
    CFG_Z_LOW    = 3'd1,
    CFG_Z_HIGH   = 3'd2,
    CFG_BOX_Z    = 3'd3,
    CFG_PERIODIC = 3'd4,
    CFG_TARGET   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0]    pos_x;
    logic signed [31:0]    pos_y;
    logic signed [31:0]    pos_z;
    logic signed [31:0]    vel_x;
    logic signed [31:0]    vel_y;
    logic signed [15:0]    dir_x;
    logic signed [15:0]    dir_y;
    logic signed [15:0]    dir_z;
    logic [GROUP_BITS-1:0] group_mask;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic signed [31:0] new_vx;
    logic signed [31:0] new_vy;
    logic signed [15:0] new_dx;
    logic signed [15:0] new_dy;
    logic signed [15:0] new_dz;
    logic               applied;
    logic               degenerate;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic               applied;
    logic               degen;
  } pass_t;

  typedef struct packed {
    pass_t       p;
    logic [31:0] ax;
    logic [31:0] ay;
  } geo_t;

  typedef struct packed {
    pass_t              p;
    logic signed [31:0] nnx;
    logic signed [31:0] nny;
    logic signed [31:0] posx;
    logic signed [31:0] posy;
  } vel_t;

  typedef struct packed {
    pass_t              p;
    logic signed [31:0] posx;
    logic signed [31:0] posy;
    logic signed [31:0] nvx;
    logic signed [31:0] nvy;
    logic [31:0]        atx;
    logic [31:0]        aty;
    logic [31:0]        atz;
    logic               sx;
    logic               sy;
    logic               sz;
    logic               dir_zero;
  } tan_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [63:0] rem;
    logic        qb;
  } dstep_t;

  function automatic logic signed [63:0] ext16(input logic signed [15:0] a);
    return {{48{a[15]}}, a};
  endfunction

  function automatic logic signed [63:0] ext32(input logic signed [31:0] a);
    return {{32{a[31]}}, a};
  endfunction

  function automatic logic signed [63:0] ext34(input logic signed [33:0] a);
    return {{30{a[33]}}, a};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
    logic signed [31:0] o;
    if (a > 64'sd2147483647) begin
      o = 32'sh7FFFFFFF;
    end else if (a < -64'sd2147483648) begin
      o = 32'sh80000000;
    end else begin
      o = a[31:0];
    end
    return o;
  endfunction

  // one digit of the integer square root, step k of SQRT_STEPS
  function automatic sqrt_t isqrt_step(input logic [63:0] v, input logic [63:0] res,
                                       input int k);
    logic [63:0] bitv;
    logic [63:0] trial;
    sqrt_t       o;
    bitv  = 64'd1 << (62 - 2 * k);
    trial = res + bitv;
    if (v >= trial) begin
      o.v   = v - trial;
      o.res = (res >> 1) + bitv;
    end else begin
      o.v   = v;
      o.res = res >> 1;
    end
    return o;
  endfunction

  // one quotient bit of a restoring division
  function automatic dstep_t div_step(input logic [63:0] rem, input logic [31:0] d,
                                      input int b);
    logic [63:0] sh;
    dstep_t      o;
    sh = {32'd0, d} << b;
    if (rem >= sh) begin
      o.rem = rem - sh;
      o.qb  = 1'b1;
    end else begin
      o.rem = rem;
      o.qb  = 1'b0;
    end
    return o;
  endfunction

endpackage

>>> rtl/cylinder_surface_projection.sv
// ----------------------------------------------------------------------------
// cylinder_surface_projection
// Pipelined projection of particles onto a cylinder around the z axis.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one particle per transfer (in_valid/in_ready, payload in_data).
//   out_* : one result per particle, in order (out_valid/out_ready, out_data).
//   cfg_* : register writes, index + data; cfg_ready is always high. Write only
//           while no particle is in flight.
// Datapath: two 32-step square root pipelines and two restoring division
//   pipelines of 31 and 15 steps, one digit per stage.
// Throughput: one particle per cycle while the output is not blocked.
// Reset: clears all valid bits and loads register defaults (radius 1.0,
//   z bounds -10.0/10.0, box 20.0, wrap off, all groups).
// Stall: the result waits in the output register while out_ready is low; the
//   pipeline halts as a whole only while its last stage and the output
//   register are both full and out_ready is low. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module cylinder_surface_projection (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  csp_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output csp_pkg::out_t                       out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [31:0]                         cfg_data
);

  localparam int DEPTH = csp_pkg::PIPE_DEPTH;
  localparam int SQ    = csp_pkg::SQRT_STEPS;
  localparam int D1    = csp_pkg::DIV1_STEPS;
  localparam int D2    = csp_pkg::DIV2_STEPS;

  logic [30:0]                     radius_r;
  logic signed [31:0]              z_low_r;
  logic signed [31:0]              z_high_r;
  logic [30:0]                     box_r;
  logic                            periodic_r;
  logic [csp_pkg::TG_BITS-1:0]     tg_r;

  logic [DEPTH-1:0]                vld_r;
  logic                            out_valid_r;
  csp_pkg::out_t                   out_r;
  csp_pkg::out_t                   out_nxt;
  logic                            en;

  assign en        = out_ready || !out_valid_r || !vld_r[DEPTH-1];
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= csp_pkg::RADIUS_RST;
      z_low_r    <= csp_pkg::Z_LOW_RST;
      z_high_r   <= csp_pkg::Z_HIGH_RST;
      box_r      <= csp_pkg::BOX_RST;
      periodic_r <= 1'b0;
      tg_r       <= csp_pkg::TG_ALL;
    end else if (cfg_valid) begin
      case (csp_pkg::cfg_idx_t'(cfg_index))
        csp_pkg::CFG_RADIUS:   radius_r   <= cfg_data[30:0];
        csp_pkg::CFG_Z_LOW:    z_low_r    <= cfg_data;
        csp_pkg::CFG_Z_HIGH:   z_high_r   <= cfg_data;
        csp_pkg::CFG_BOX_Z:    box_r      <= cfg_data[30:0];
        csp_pkg::CFG_PERIODIC: periodic_r <= cfg_data[0];
        csp_pkg::CFG_TARGET:   tg_r       <= cfg_data[csp_pkg::TG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[DEPTH-2:0], in_valid};
      end
      if (en && vld_r[DEPTH-1]) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[DEPTH-1]) begin
      out_r <= out_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // group select, z wrap, magnitudes, squares
  // --------------------------------------------------------------------------
  csp_pkg::geo_t   s1_nxt, s1_r, s2_r, s3_r;
  logic [63:0]     sqx_r, sqy_r, sum_r;

  always_comb begin
    logic               applied;
    logic signed [63:0] zw;
    applied = (tg_r >= csp_pkg::TG_ALL) ? 1'b1 :
              in_data.group_mask[tg_r[csp_pkg::GIDX_BITS-1:0]];
    zw = csp_pkg::ext32(in_data.pos_z);
    if (applied && periodic_r) begin
      if ($signed(in_data.pos_z) > z_high_r) begin
        zw = zw - $signed({33'd0, box_r});
      end else if ($signed(in_data.pos_z) < z_low_r) begin
        zw = zw + $signed({33'd0, box_r});
      end
    end
    s1_nxt.p.x       = in_data.pos_x;
    s1_nxt.p.y       = in_data.pos_y;
    s1_nxt.p.z       = csp_pkg::sat32(zw);
    s1_nxt.p.vx      = in_data.vel_x;
    s1_nxt.p.vy      = in_data.vel_y;
    s1_nxt.p.dx      = in_data.dir_x;
    s1_nxt.p.dy      = in_data.dir_y;
    s1_nxt.p.dz      = in_data.dir_z;
    s1_nxt.p.applied = applied;
    s1_nxt.p.degen   = 1'b0;
    s1_nxt.ax = in_data.pos_x[31] ? (~in_data.pos_x + 32'd1) : in_data.pos_x;
    s1_nxt.ay = in_data.pos_y[31] ? (~in_data.pos_y + 32'd1) : in_data.pos_y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      s2_r  <= s1_r;
      sqx_r <= {32'd0, s1_r.ax} * {32'd0, s1_r.ax};
      sqy_r <= {32'd0, s1_r.ay} * {32'd0, s1_r.ay};
      s3_r  <= s2_r;
      sum_r <= sqx_r + sqy_r;
    end
  end

  // --------------------------------------------------------------------------
  // radial distance
  // --------------------------------------------------------------------------
  logic [63:0]     q1v_r [SQ];
  logic [63:0]     q1s_r [SQ];
  csp_pkg::geo_t   q1c_r [SQ];

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt1
    csp_pkg::sqrt_t st_nxt;
    csp_pkg::geo_t  c_in;
    if (k == 0) begin : g_first
      assign st_nxt = csp_pkg::isqrt_step(sum_r, 64'd0, k);
      assign c_in   = s3_r;
    end else begin : g_next
      assign st_nxt = csp_pkg::isqrt_step(q1v_r[k-1], q1s_r[k-1], k);
      assign c_in   = q1c_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q1v_r[k] <= st_nxt.v;
        q1s_r[k] <= st_nxt.res;
        q1c_r[k] <= c_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // numerators for normal and scaled position
  // --------------------------------------------------------------------------
  csp_pkg::geo_t   m_nxt, m_r, n_r;
  logic [31:0]     rm_r, rn_r;
  logic [63:0]     mpx_r, mpy_r;
  logic [63:0]     num_r [4];

  always_comb begin
    m_nxt         = q1c_r[SQ-1];
    m_nxt.p.degen = m_nxt.p.applied && (q1s_r[SQ-1][31:0] == 32'd0 || radius_r == 31'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r      <= m_nxt;
      rm_r     <= q1s_r[SQ-1][31:0];
      mpx_r    <= {32'd0, q1c_r[SQ-1].ax} * {33'd0, radius_r};
      mpy_r    <= {32'd0, q1c_r[SQ-1].ay} * {33'd0, radius_r};
      n_r      <= m_r;
      rn_r     <= rm_r;
      num_r[0] <= {2'd0, m_r.ax, 30'd0} + {33'd0, rm_r[31:1]};
      num_r[1] <= {2'd0, m_r.ay, 30'd0} + {33'd0, rm_r[31:1]};
      num_r[2] <= mpx_r + {33'd0, rm_r[31:1]};
      num_r[3] <= mpy_r + {33'd0, rm_r[31:1]};
    end
  end

  // --------------------------------------------------------------------------
  // division by radial distance, four lanes
  // --------------------------------------------------------------------------
  logic [63:0]     d1_rem_r [D1][4];
  logic [D1-1:0]   d1_q_r   [D1][4];
  logic [31:0]     d1_d_r   [D1];
  csp_pkg::geo_t   d1_c_r   [D1];

  for (genvar j = 0; j < D1; j++) begin : g_div1
    logic [63:0]      rem_in [4];
    logic [D1-1:0]    q_in   [4];
    logic [31:0]      d_in;
    csp_pkg::geo_t    c_in;
    csp_pkg::dstep_t  st [4];
    if (j == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 4; l++) begin
          rem_in[l] = num_r[l];
          q_in[l]   = '0;
        end
      end
      assign d_in = rn_r;
      assign c_in = n_r;
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 4; l++) begin
          rem_in[l] = d1_rem_r[j-1][l];
          q_in[l]   = d1_q_r[j-1][l];
        end
      end
      assign d_in = d1_d_r[j-1];
      assign c_in = d1_c_r[j-1];
    end
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        st[l] = csp_pkg::div_step(rem_in[l], d_in, D1 - 1 - j);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 4; l++) begin
          d1_rem_r[j][l] <= st[l].rem;
          d1_q_r[j][l]   <= {q_in[l][D1-2:0], st[l].qb};
        end
        d1_d_r[j] <= d_in;
        d1_c_r[j] <= c_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // velocity and director projection
  // --------------------------------------------------------------------------
  csp_pkg::vel_t        p_nxt, p_r, v1_r, v2_r, v3_r, v4_r;
  logic signed [63:0]   pvx_r, pvy_r, pdx_r, pdy_r;
  logic signed [33:0]   vn_r, dn_r;
  logic signed [63:0]   pvnx_r, pvny_r, pdnx_r, pdny_r;
  logic signed [31:0]   nvx_r, nvy_r;
  logic signed [33:0]   tx_r, ty_r, tz_r;
  logic signed [33:0]   vn_nxt, dn_nxt;
  logic signed [31:0]   nvx_nxt, nvy_nxt;
  logic signed [33:0]   tx_nxt, ty_nxt, tz_nxt;

  always_comb begin
    csp_pkg::geo_t      c;
    logic signed [31:0] m [4];
    c = d1_c_r[D1-1];
    for (int l = 0; l < 4; l++) begin
      m[l] = $signed({1'b0, d1_q_r[D1-1][l]});
    end
    p_nxt.p    = c.p;
    p_nxt.nnx  = c.p.x[31] ? -m[0] : m[0];
    p_nxt.nny  = c.p.y[31] ? -m[1] : m[1];
    p_nxt.posx = c.p.x[31] ? -m[2] : m[2];
    p_nxt.posy = c.p.y[31] ? -m[3] : m[3];
  end

  always_comb begin
    logic signed [63:0] t;
    logic signed [63:0] u;
    t      = pvx_r + pvy_r + 64'sd536870912;
    u      = pdx_r + pdy_r + 64'sd32768;
    vn_nxt = t[63:30];
    dn_nxt = u[49:16];
  end

  always_comb begin
    logic signed [63:0] rx, ry, ex, ey;
    logic signed [33:0] a, b, c2, d;
    rx = pvnx_r + 64'sd536870912;
    ry = pvny_r + 64'sd536870912;
    ex = pdnx_r + 64'sd536870912;
    ey = pdny_r + 64'sd536870912;
    a  = rx[63:30];
    b  = ry[63:30];
    c2 = ex[63:30];
    d  = ey[63:30];
    nvx_nxt = csp_pkg::sat32(csp_pkg::ext32(v3_r.p.vx) - csp_pkg::ext34(a));
    nvy_nxt = csp_pkg::sat32(csp_pkg::ext32(v3_r.p.vy) - csp_pkg::ext34(b));
    tx_nxt  = 34'((csp_pkg::ext16(v3_r.p.dx) <<< 14) - csp_pkg::ext34(c2));
    ty_nxt  = 34'((csp_pkg::ext16(v3_r.p.dy) <<< 14) - csp_pkg::ext34(d));
    tz_nxt  = 34'(csp_pkg::ext16(v3_r.p.dz) <<< 14);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= p_nxt;
      v1_r   <= p_r;
      pvx_r  <= csp_pkg::ext32(p_r.p.vx) * csp_pkg::ext32(p_r.nnx);
      pvy_r  <= csp_pkg::ext32(p_r.p.vy) * csp_pkg::ext32(p_r.nny);
      pdx_r  <= csp_pkg::ext16(p_r.p.dx) * csp_pkg::ext32(p_r.nnx);
      pdy_r  <= csp_pkg::ext16(p_r.p.dy) * csp_pkg::ext32(p_r.nny);
      v2_r   <= v1_r;
      vn_r   <= vn_nxt;
      dn_r   <= dn_nxt;
      v3_r   <= v2_r;
      pvnx_r <= csp_pkg::ext34(vn_r) * csp_pkg::ext32(v2_r.nnx);
      pvny_r <= csp_pkg::ext34(vn_r) * csp_pkg::ext32(v2_r.nny);
      pdnx_r <= csp_pkg::ext34(dn_r) * csp_pkg::ext32(v2_r.nnx);
      pdny_r <= csp_pkg::ext34(dn_r) * csp_pkg::ext32(v2_r.nny);
      v4_r   <= v3_r;
      nvx_r  <= nvx_nxt;
      nvy_r  <= nvy_nxt;
      tx_r   <= tx_nxt;
      ty_r   <= ty_nxt;
      tz_r   <= tz_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // director length
  // --------------------------------------------------------------------------
  csp_pkg::tan_t   v5_nxt, v5_r, v6_r;
  logic [63:0]     sqtx_r, sqty_r, sqtz_r, sum2_r;

  always_comb begin
    logic signed [33:0] ax, ay, az;
    ax = tx_r[33] ? -tx_r : tx_r;
    ay = ty_r[33] ? -ty_r : ty_r;
    az = tz_r[33] ? -tz_r : tz_r;
    v5_nxt.p        = v4_r.p;
    v5_nxt.posx     = v4_r.posx;
    v5_nxt.posy     = v4_r.posy;
    v5_nxt.nvx      = nvx_r;
    v5_nxt.nvy      = nvy_r;
    v5_nxt.atx      = ax[31:0];
    v5_nxt.aty      = ay[31:0];
    v5_nxt.atz      = az[31:0];
    v5_nxt.sx       = tx_r[33];
    v5_nxt.sy       = ty_r[33];
    v5_nxt.sz       = tz_r[33];
    v5_nxt.dir_zero = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v5_r   <= v5_nxt;
      sqtx_r <= {32'd0, v5_nxt.atx} * {32'd0, v5_nxt.atx};
      sqty_r <= {32'd0, v5_nxt.aty} * {32'd0, v5_nxt.aty};
      sqtz_r <= {32'd0, v5_nxt.atz} * {32'd0, v5_nxt.atz};
      v6_r   <= v5_r;
      sum2_r <= sqtx_r + sqty_r + sqtz_r;
    end
  end

  logic [63:0]     q2v_r [SQ];
  logic [63:0]     q2s_r [SQ];
  csp_pkg::tan_t   q2c_r [SQ];

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt2
    csp_pkg::sqrt_t st_nxt;
    csp_pkg::tan_t  c_in;
    if (k == 0) begin : g_first
      assign st_nxt = csp_pkg::isqrt_step(sum2_r, 64'd0, k);
      assign c_in   = v6_r;
    end else begin : g_next
      assign st_nxt = csp_pkg::isqrt_step(q2v_r[k-1], q2s_r[k-1], k);
      assign c_in   = q2c_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q2v_r[k] <= st_nxt.v;
        q2s_r[k] <= st_nxt.res;
        q2c_r[k] <= c_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // director normalization, three lanes
  // --------------------------------------------------------------------------
  csp_pkg::tan_t   l_nxt, l_r;
  logic [31:0]     len_r;
  logic [63:0]     num2_r [3];
  logic [31:0]     len_nxt;

  always_comb begin
    len_nxt        = q2s_r[SQ-1][31:0];
    l_nxt          = q2c_r[SQ-1];
    l_nxt.dir_zero = (len_nxt == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_r       <= l_nxt;
      len_r     <= len_nxt;
      num2_r[0] <= {18'd0, l_nxt.atx, 14'd0} + {33'd0, len_nxt[31:1]};
      num2_r[1] <= {18'd0, l_nxt.aty, 14'd0} + {33'd0, len_nxt[31:1]};
      num2_r[2] <= {18'd0, l_nxt.atz, 14'd0} + {33'd0, len_nxt[31:1]};
    end
  end

  logic [63:0]     d2_rem_r [D2][3];
  logic [D2-1:0]   d2_q_r   [D2][3];
  logic [31:0]     d2_d_r   [D2];
  csp_pkg::tan_t   d2_c_r   [D2];

  for (genvar j = 0; j < D2; j++) begin : g_div2
    logic [63:0]      rem_in [3];
    logic [D2-1:0]    q_in   [3];
    logic [31:0]      d_in;
    csp_pkg::tan_t    c_in;
    csp_pkg::dstep_t  st [3];
    if (j == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_in[l] = num2_r[l];
          q_in[l]   = '0;
        end
      end
      assign d_in = len_r;
      assign c_in = l_r;
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_in[l] = d2_rem_r[j-1][l];
          q_in[l]   = d2_q_r[j-1][l];
        end
      end
      assign d_in = d2_d_r[j-1];
      assign c_in = d2_c_r[j-1];
    end
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        st[l] = csp_pkg::div_step(rem_in[l], d_in, D2 - 1 - j);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          d2_rem_r[j][l] <= st[l].rem;
          d2_q_r[j][l]   <= {q_in[l][D2-2:0], st[l].qb};
        end
        d2_d_r[j] <= d_in;
        d2_c_r[j] <= c_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result select
  // --------------------------------------------------------------------------
  always_comb begin
    csp_pkg::tan_t      c;
    logic signed [15:0] m [3];
    c = d2_c_r[D2-1];
    for (int l = 0; l < 3; l++) begin
      m[l] = $signed({1'b0, d2_q_r[D2-1][l]});
    end
    out_nxt.new_x      = c.p.x;
    out_nxt.new_y      = c.p.y;
    out_nxt.new_z      = c.p.z;
    out_nxt.new_vx     = c.p.vx;
    out_nxt.new_vy     = c.p.vy;
    out_nxt.new_dx     = c.p.dx;
    out_nxt.new_dy     = c.p.dy;
    out_nxt.new_dz     = c.p.dz;
    out_nxt.applied    = c.p.applied;
    out_nxt.degenerate = c.p.applied && c.p.degen;
    if (c.p.applied && !c.p.degen) begin
      out_nxt.new_x  = c.posx;
      out_nxt.new_y  = c.posy;
      out_nxt.new_vx = c.nvx;
      out_nxt.new_vy = c.nvy;
      if (c.dir_zero) begin
        out_nxt.degenerate = 1'b1;
      end else begin
        out_nxt.new_dx = c.sx ? -m[0] : m[0];
        out_nxt.new_dy = c.sy ? -m[1] : m[1];
        out_nxt.new_dz = c.sz ? -m[2] : m[2];
      end
    end
  end

`ifndef ASSERT_OFF
  a_degen_needs_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.applied || !out_data.degenerate))
    else $error("degenerate result on a particle outside the group");

  a_stall_only_on_block: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && vld_r[DEPTH-1]))
    else $error("input held without a blocked result");

  a_last_stage_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[DEPTH-1] && en) |=> out_valid)
    else $error("finished item did not reach the output register");
`endif

endmodule
